// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the checker file, tslg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on aclk, off while aresetn is low.
`define TSLG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TSLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tslg_pkg.sv =====
package tslg_pkg;

    localparam int FS_HZ_DEF       = 48000;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SINE_LEN        = 256;

    localparam int PHASE_W = 16;
    localparam int RATE_W  = 10;
    localparam int DEPTH_W = 9;
    localparam int SINE_W  = 8;
    localparam int GAIN_W  = 9;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LFO_RATE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_DEPTH     = 2'd2;

    localparam int                 RATE_RESET  = 50;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 9'd128;

    localparam logic [SINE_W:0]  SINE_MID = 9'd128;
    // x/127 == (x * 66053) >> 23, exact for x < 2**16
    localparam logic [16:0]      RECIP_127   = 17'd66053;
    localparam int               RECIP_SHIFT = 23;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 9'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                   wr;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    localparam logic [SINE_W-1:0] SINE_ROM [0:SINE_LEN-1] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd240, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd206, 8'd203, 8'd201,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd100, 8'd97,  8'd94,  8'd91,  8'd88,  8'd85,  8'd82,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd68,  8'd65,  8'd62,  8'd60,
        8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd45,  8'd42,  8'd40,
        8'd38,  8'd36,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd24,
        8'd22,  8'd20,  8'd19,  8'd17,  8'd15,  8'd14,  8'd13,  8'd11,
        8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd4,
        8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
        8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd17,  8'd19,  8'd20,
        8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd36,
        8'd38,  8'd40,  8'd42,  8'd45,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// ===== hdl/tslg_queue.sv =====
module tslg_queue #(
    parameter int DATA_W = tslg_pkg::SAMPLE_BITS_DEF + tslg_pkg::SINE_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int DEPTH = tslg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/tslg_step_div.sv =====
// Phase step: step = (rate << 16) / (FS_HZ * 10), by a multiply with the rounded-up
// reciprocal of the divisor; the new step is registered and valid in the cycle after start.
module tslg_step_div #(
    parameter int FS_HZ = tslg_pkg::FS_HZ_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tslg_pkg::RATE_W-1:0]  rate,
    output logic                         busy,
    output logic                         done,
    output logic [tslg_pkg::PHASE_W-1:0] step
);

    localparam logic [63:0] DIVISOR     = 64'(FS_HZ) * 64'd10;
    localparam int          RECIP_SHIFT = 31;
    localparam int          RECIP_W     = 31;
    localparam int          PROD_W      = tslg_pkg::RATE_W + RECIP_W;
    localparam int          QUO_W       = PROD_W - RECIP_SHIFT;
    // ceil(2**47 / DIVISOR); exact while rate * DIVISOR < 2**31
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (RECIP_SHIFT + tslg_pkg::PHASE_W)) + DIVISOR - 64'd1) / DIVISOR;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                         busy_reg, busy_next;
    logic [tslg_pkg::PHASE_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0]            prod;
    logic [QUO_W-1:0]             quo;

    always_comb begin
        prod = {{(PROD_W - tslg_pkg::RATE_W){1'b0}}, rate} *
               {{(PROD_W - RECIP_W){1'b0}}, RECIP};
        quo  = prod[PROD_W-1:RECIP_SHIFT];

        busy_next = start;
        step_next = step_reg;
        if (start) begin
            // a nonzero rate never gives a zero step
            if ((quo == '0) && (rate != '0)) begin
                step_next = tslg_pkg::PHASE_W'(1);
            end else begin
                step_next = {{(tslg_pkg::PHASE_W - QUO_W){1'b0}}, quo};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
    end

    assign busy = busy_reg;
    // the step is valid during the single busy cycle
    assign done = busy_reg;
    assign step = step_reg;

endmodule

// ===== hdl/tslg_front.sv =====
// Intake: takes samples, advances the LFO phase while the effect is enabled and looks up the sine for each word.
module tslg_front #(
    parameter int SAMPLE_BITS = tslg_pkg::SAMPLE_BITS_DEF,
    parameter int FS_HZ       = tslg_pkg::FS_HZ_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tslg_pkg::cfg_wr_t                     cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [SAMPLE_BITS-1:0]                s_sample_in,
    input  logic                                  div_busy,
    input  logic                                  div_done,
    input  logic [tslg_pkg::PHASE_W-1:0]          div_step,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output logic [SAMPLE_BITS+tslg_pkg::SINE_W:0] push_data
);

    localparam int unsigned STEP_RAW =
        (tslg_pkg::RATE_RESET * tslg_pkg::SINE_LEN * 256) / (FS_HZ * 10);
    localparam logic [tslg_pkg::PHASE_W-1:0] STEP_RESET =
        ((STEP_RAW == 0) && (tslg_pkg::RATE_RESET > 0)) ? tslg_pkg::PHASE_W'(1)
                                                        : tslg_pkg::PHASE_W'(STEP_RAW);

    logic                          enable_reg, enable_next;
    logic [tslg_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [tslg_pkg::PHASE_W-1:0]  step_reg, step_next;
    logic [tslg_pkg::PHASE_W-1:0]  phase_sum;
    logic [tslg_pkg::SINE_W-1:0]   sine;
    logic                          accept;

    assign s_ready    = push_ready && !div_busy;
    assign push_valid = s_valid && !div_busy;
    assign accept     = s_valid && s_ready;

    assign phase_sum = phase_reg + step_reg;
    assign sine      = tslg_pkg::SINE_ROM[phase_sum[tslg_pkg::PHASE_W-1 -: tslg_pkg::SINE_W]];
    assign push_data = {!enable_reg, sine, s_sample_in};

    always_comb begin
        enable_next = enable_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        if (cfg.wr && (cfg.index == tslg_pkg::CFG_EFFECT_ENABLE)) begin
            enable_next = cfg.data[0];
        end
        if (div_done) begin
            step_next = div_step;
        end
        if (accept && enable_reg) begin
            phase_next = phase_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            phase_reg  <= '0;
            step_reg   <= STEP_RESET;
        end else begin
            enable_reg <= enable_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
        end
    end

endmodule

// ===== hdl/tslg_back.sv =====
// Gain and scale: one word at a time through a short sequence of registered steps.
module tslg_back #(
    parameter int SAMPLE_BITS = tslg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tslg_pkg::cfg_wr_t                     cfg,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  logic [SAMPLE_BITS+tslg_pkg::SINE_W:0] pop_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [SAMPLE_BITS-1:0]                m_sample_out
);

    localparam int ENTRY_W = SAMPLE_BITS + tslg_pkg::SINE_W + 1;
    localparam int MOD_W   = tslg_pkg::SINE_W + 1 + tslg_pkg::DEPTH_W + 1;
    localparam int MAG_W   = 16;
    localparam int RPROD_W = MAG_W + 17;
    localparam int SUM_W   = tslg_pkg::DEPTH_W + 3;
    localparam int PROD_W  = SAMPLE_BITS + tslg_pkg::GAIN_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_GAIN = 2'd2;
    localparam logic [1:0] ST_MUL  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic                          m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]        out_reg, out_next;
    logic [tslg_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [SAMPLE_BITS-1:0]        sample_reg, sample_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [tslg_pkg::DEPTH_W-1:0]  quo_reg, quo_next;
    logic [tslg_pkg::GAIN_W-1:0]   gain_reg, gain_next;

    logic                          head_bypass;
    logic [tslg_pkg::SINE_W-1:0]   head_sine;
    logic signed [tslg_pkg::SINE_W:0] off;
    logic signed [MOD_W-1:0]       modp;
    logic [MOD_W-1:0]              modp_abs;
    logic [RPROD_W-1:0]            rprod;
    logic signed [SUM_W-1:0]       quo_s, gain_raw;
    logic signed [PROD_W-1:0]      prod;
    logic                          out_free, take;

    assign head_bypass = pop_data[ENTRY_W-1];
    assign head_sine   = pop_data[SAMPLE_BITS +: tslg_pkg::SINE_W];

    assign out_free  = !m_valid_reg || m_ready;
    assign take      = pop_valid &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_MUL) && out_free));
    assign pop_ready = take;

    always_comb begin
        off      = $signed({1'b0, head_sine}) - $signed(tslg_pkg::SINE_MID);
        modp     = off * $signed({1'b0, depth_reg});
        modp_abs = modp[MOD_W-1] ? -modp : modp;

        rprod = {{(RPROD_W - MAG_W){1'b0}}, mag_reg} *
                {{(RPROD_W - 17){1'b0}}, tslg_pkg::RECIP_127};

        quo_s    = neg_reg ? -$signed({3'b000, quo_reg}) : $signed({3'b000, quo_reg});
        gain_raw = SUM_W'(256) - $signed({3'b000, depth_reg}) + quo_s;

        prod = $signed(sample_reg) * $signed({1'b0, gain_reg});
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        depth_next   = depth_reg;
        sample_next  = sample_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        gain_next    = gain_reg;

        if (cfg.wr && (cfg.index == tslg_pkg::CFG_MOD_DEPTH)) begin
            depth_next = cfg.data[tslg_pkg::DEPTH_W-1:0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
            end
            ST_DIV: begin
                quo_next   = rprod[tslg_pkg::RECIP_SHIFT +: tslg_pkg::DEPTH_W];
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                if (gain_raw > $signed(SUM_W'(tslg_pkg::GAIN_MAX))) begin
                    gain_next = tslg_pkg::GAIN_MAX;
                end else if (gain_raw < $signed(SUM_W'(tslg_pkg::GAIN_MIN))) begin
                    gain_next = tslg_pkg::GAIN_MIN;
                end else begin
                    gain_next = gain_raw[tslg_pkg::GAIN_W-1:0];
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (out_free) begin
                    // arithmetic shift by 8 rounds toward minus infinity
                    out_next     = prod[SAMPLE_BITS+7:8];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (take) begin
            sample_next = pop_data[SAMPLE_BITS-1:0];
            if (head_bypass) begin
                gain_next  = tslg_pkg::GAIN_MAX;
                state_next = ST_MUL;
            end else begin
                mag_next   = modp_abs[MAG_W-1:0];
                neg_next   = modp[MOD_W-1];
                state_next = ST_DIV;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            depth_reg   <= tslg_pkg::DEPTH_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            depth_reg   <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg    <= out_next;
        sample_reg <= sample_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        gain_reg   <= gain_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

endmodule

// ===== hdl/tremolo_sine_lfo_gain.sv =====
// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    s_sample_in  (signed sample)
// m_        out  m_valid / m_ready    m_sample_out (signed sample)
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Tremolo words: queue, then depth product, divide by 127 through a reciprocal multiply,
// gain clamp, sample multiply; a new word is taken only when the last one leaves the multiply.
// Bypass words go straight to the multiply, one word per cycle sustained while m_ready is high.
// A 2-word queue lets intake run ahead while the output register is stalled.
// A lfo_rate write holds cfg_ready and s_ready low for one cycle while the step loads.
// Reset is synchronous, active low; no memory clearing is needed.
module tremolo_sine_lfo_gain #(
    parameter int FS_HZ       = tslg_pkg::FS_HZ_DEF,
    parameter int SAMPLE_BITS = tslg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tslg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tslg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SAMPLE_BITS-1:0]           s_sample_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [SAMPLE_BITS-1:0]           m_sample_out
);

    localparam int ENTRY_W = SAMPLE_BITS + tslg_pkg::SINE_W + 1;

    tslg_pkg::cfg_wr_t              cfg;
    logic                           div_busy, div_done, div_start;
    logic [tslg_pkg::PHASE_W-1:0]   div_step;
    logic                           push_valid, push_ready, pop_valid, pop_ready;
    logic [ENTRY_W-1:0]             push_data, pop_data;

    assign cfg_ready = !div_busy;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign div_start = cfg.wr && (cfg.index == tslg_pkg::CFG_LFO_RATE);

    tslg_step_div #(
        .FS_HZ(FS_HZ)
    ) u_step_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .rate   (cfg_data[tslg_pkg::RATE_W-1:0]),
        .busy   (div_busy),
        .done   (div_done),
        .step   (div_step)
    );

    tslg_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FS_HZ      (FS_HZ)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_in(s_sample_in),
        .div_busy   (div_busy),
        .div_done   (div_done),
        .div_step   (div_step),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tslg_queue #(
        .DATA_W(ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    tslg_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out)
    );

endmodule

// ===== hdl/tslg_checker.sv =====
`include "assert_macros.svh"

module tslg_checker #(
    parameter int SAMPLE_BITS = tslg_pkg::SAMPLE_BITS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [tslg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [tslg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [SAMPLE_BITS-1:0]           s_sample_in,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [SAMPLE_BITS-1:0]           m_sample_out
);

    logic rate_wr;
    assign rate_wr = cfg_valid && cfg_ready && (cfg_index == tslg_pkg::CFG_LFO_RATE);

    `TSLG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "output word dropped")
    `TSLG_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_sample_out), "held word changed")
    `TSLG_ASSERT(a_busy_blocks_in, !cfg_ready |-> !s_ready, "sample taken during step update")
    `TSLG_ASSERT_NEXT(a_rate_wr_busy, rate_wr, !cfg_ready && !s_ready, "step update not started")

endmodule

bind tremolo_sine_lfo_gain tslg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tslg_checker (.*);

// ===== sim/tb_tremolo_sine_lfo_gain.sv =====
`timescale 1ns / 1ps

module tb_tremolo_sine_lfo_gain;

    localparam logic [tslg_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 80;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tslg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tslg_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [23:0]                      s_sample_in;
    logic                             m_valid;
    logic                             m_ready;
    logic [23:0]                      m_sample_out;

    tremolo_sine_lfo_gain u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // predictor state
    bit          lfo_on;
    bit [9:0]    lfo_rate_q;
    bit [8:0]    depth_q;
    bit [15:0]   lfo_acc;
    bit [15:0]   lfo_inc;

    logic [23:0] pending_out [$];
    int          mismatches;
    bit          calm;
    bit          hold_req;

    typedef struct {
        bit        en;
        bit [9:0]  rate;
        bit [8:0]  depth;
        bit        junk;
        bit [23:0] smp;
        bit        known;
        bit [23:0] res;
    } dir_row_t;

    localparam int DIR_ROWS = 21;
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        // settings left at reset: bypass, then the effect enabled
        '{1'b0, 10'd50,   9'd128, 1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{1'b0, 10'd50,   9'd128, 1'b0, 24'h800000, 1'b1, 24'h800000},
        '{1'b0, 10'd50,   9'd128, 1'b0, 24'h000000, 1'b1, 24'h000000},
        '{1'b0, 10'd50,   9'd128, 1'b0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{1'b1, 10'd50,   9'd128, 1'b0, 24'h7FFFFF, 1'b0, 24'h000000},
        '{1'b1, 10'd50,   9'd128, 1'b0, 24'h800000, 1'b0, 24'h000000},
        '{1'b1, 10'd50,   9'd128, 1'b0, 24'h000000, 1'b1, 24'h000000},
        // zero depth: unity gain
        '{1'b1, 10'd50,   9'd0,   1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{1'b1, 10'd50,   9'd0,   1'b0, 24'h800000, 1'b1, 24'h800000},
        '{1'b1, 10'd50,   9'd0,   1'b0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        // depth past 256, rate past 1000
        '{1'b1, 10'd1023, 9'd511, 1'b0, 24'h7FFFFF, 1'b0, 24'h000000},
        '{1'b1, 10'd1023, 9'd511, 1'b0, 24'h800000, 1'b0, 24'h000000},
        '{1'b1, 10'd1023, 9'd511, 1'b0, 24'h000000, 1'b1, 24'h000000},
        // rate 0: phase frozen
        '{1'b1, 10'd0,    9'd256, 1'b0, 24'h400000, 1'b0, 24'h000000},
        '{1'b1, 10'd0,    9'd256, 1'b0, 24'hC00000, 1'b0, 24'h000000},
        // rate 1: step rounds to 0, forced to 1
        '{1'b1, 10'd1,    9'd1,   1'b0, 24'h000001, 1'b0, 24'h000000},
        '{1'b1, 10'd1,    9'd1,   1'b0, 24'hFFFFFF, 1'b0, 24'h000000},
        // write to unmapped index must not disturb anything
        '{1'b1, 10'd1,    9'd1,   1'b1, 24'h123456, 1'b0, 24'h000000},
        '{1'b1, 10'd700,  9'd200, 1'b0, 24'h7FFFFF, 1'b0, 24'h000000},
        '{1'b0, 10'd700,  9'd200, 1'b0, 24'h5A5A5A, 1'b1, 24'h5A5A5A},
        '{1'b1, 10'd700,  9'd200, 1'b0, 24'hA5A5A5, 1'b0, 24'h000000}
    };

    function automatic bit [15:0] rate_to_step(input bit [9:0] rate);
        longint q;
        q = (longint'(rate) * tslg_pkg::SINE_LEN * 256) /
            (longint'(tslg_pkg::FS_HZ_DEF) * 10);
        if (q == 0 && rate != 0)
            q = 1;
        return q[15:0];
    endfunction

    function automatic void lfo_reset();
        lfo_on     = 1'b0;
        lfo_rate_q = 10'(tslg_pkg::RATE_RESET);
        depth_q    = tslg_pkg::DEPTH_RESET;
        lfo_acc    = '0;
        lfo_inc    = rate_to_step(10'(tslg_pkg::RATE_RESET));
    endfunction

    function automatic void lfo_write(input logic [tslg_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [tslg_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            tslg_pkg::CFG_EFFECT_ENABLE: lfo_on = val[0];
            tslg_pkg::CFG_LFO_RATE: begin
                lfo_rate_q = val;
                lfo_inc    = rate_to_step(val);
            end
            tslg_pkg::CFG_MOD_DEPTH: depth_q = val[8:0];
            default: ;
        endcase
    endfunction

    // when the effect is on, advances the LFO and returns the modulated sample; else returns the sample
    function automatic logic [23:0] tremolo_predict(input logic [23:0] x);
        longint     smp;
        longint     off;
        longint     gain;
        longint     prod;
        logic [7:0] sine;
        if (!lfo_on)
            return x;
        lfo_acc = lfo_acc + lfo_inc;
        sine    = tslg_pkg::SINE_ROM[lfo_acc[15:8]];
        off     = longint'(sine) - 128;
        gain    = 256 - longint'(depth_q) + (off * longint'(depth_q)) / 127;
        if (gain > 256)
            gain = 256;
        if (gain < 1)
            gain = 1;
        smp = longint'($signed(x));
        if (smp == 0)
            return 24'h000000;
        prod = (smp * gain) >>> 8;
        return prod[23:0];
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'h000000;
                    3: return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            1: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    // offer one word; valid is left high so back-to-back words need no dip
    task automatic send_sample(input logic [23:0] smp, input bit known,
                               input logic [23:0] res);
        logic [23:0] pred;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        do @(posedge aclk); while (!s_ready);
        pred = tremolo_predict(smp);
        pending_out.push_back(known ? res : pred);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
    endtask

    task automatic write_reg(input logic [tslg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tslg_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        lfo_write(idx, val);
    endtask

    task automatic set_regs(input bit en, input bit [9:0] rate, input bit [8:0] depth,
                            input bit junk);
        bit [9:0] noise;
        noise = 10'($urandom);
        drain();
        write_reg(tslg_pkg::CFG_EFFECT_ENABLE, {noise[9:1], en});
        write_reg(tslg_pkg::CFG_LFO_RATE, rate);
        write_reg(tslg_pkg::CFG_MOD_DEPTH, {noise[0], depth});
        if (junk)
            write_reg(CFG_UNUSED, 10'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold on request
    initial begin
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, got sample_out %h",
                         $time, m_sample_out);
                mismatches++;
            end else begin
                if (m_sample_out !== pending_out[0]) begin
                    $display("%0t ns: sample_out expected %h, got %h",
                             $time, pending_out[0], m_sample_out);
                    mismatches++;
                end
                void'(pending_out.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        bit       en;
        bit [9:0] rate;
        bit [8:0] depth;
        int       n_items;

        mismatches  = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        lfo_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].en != lfo_on || dir_tab[i].rate != lfo_rate_q ||
                dir_tab[i].depth != depth_q || dir_tab[i].junk)
                set_regs(dir_tab[i].en, dir_tab[i].rate, dir_tab[i].depth, dir_tab[i].junk);
            send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].res);
        end

        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: begin en = 1'b1; rate = 10'd1023; depth = 9'd511; end
                1: begin en = 1'b1; rate = 10'd0;    depth = 9'd256; end
                2: begin en = 1'b1; rate = 10'd1;    depth = 9'd0;   end
                3: begin en = 1'b0; rate = 10'd1000; depth = 9'd1;   end
                default: begin
                    en    = ($urandom_range(0, 5) != 0);
                    rate  = 10'($urandom_range(0, 1023));
                    depth = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(257, 511))
                                                        : 9'($urandom_range(0, 256));
                end
            endcase
            set_regs(en, rate, depth, $urandom_range(0, 3) == 0);
            n_items = $urandom_range(80, 120);
            for (int k = 0; k < n_items; k++) begin
                if (k == 40 && ph % 2 == 1)
                    hold_req = 1'b1;
                if (k == 60 && ph % 3 == 2)
                    drain();
                send_sample(rand_sample(), 1'b0, '0);
            end
        end

        // last stretch runs at full rate on both sides
        set_regs(1'b1, 10'($urandom_range(600, 1023)), 9'd256, 1'b0);
        calm = 1'b1;
        for (int k = 0; k < 100; k++)
            send_sample(rand_sample(), 1'b0, '0);

        drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tslg_pkg.sv
hdl/tslg_queue.sv
hdl/tslg_step_div.sv
hdl/tslg_front.sv
hdl/tslg_back.sv
hdl/tremolo_sine_lfo_gain.sv
hdl/tslg_checker.sv
sim/tb_tremolo_sine_lfo_gain.sv
